>>> rtl/ptc_pkg.sv
// shared widths, constants, register codes and stage types for the compensation pipeline
package ptc_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int DT_W     = RAW_W + 1;
    localparam int PROD_W   = DT_W + CAL_W + 1;
    localparam int DD_W     = 2 * DT_W;
    localparam int TC_SHIFT = 23;
    localparam int OC_SHIFT = 6;
    localparam int SC_SHIFT = 7;
    localparam int T2_SHIFT = 31;
    localparam int OFF_BASE_SHIFT  = 17;
    localparam int SENS_BASE_SHIFT = 16;
    localparam int LO_W     = PROD_W - TC_SHIFT;
    localparam int TEMP1_W  = LO_W + 1;
    localparam int VL_W     = LO_W + 1;
    localparam int OFF1_W   = 37;
    localparam int SENS1_W  = 36;
    localparam int T2_W     = 17;
    localparam int SQ_W     = 36;
    localparam int TEMP_W   = TEMP1_W + 1;
    localparam int OS_W     = 40;
    localparam int TOUT_W   = 15;
    localparam int POUT_W   = 17;
    localparam int SPLIT    = 20;
    localparam int PL_W     = RAW_W + SPLIT;
    localparam int PH_W     = RAW_W + 1 + OS_W - SPLIT;
    localparam int PSUM_W   = PH_W + SPLIT;
    localparam int PSENS_SHIFT = 21;
    localparam int Q_W      = PSUM_W - PSENS_SHIFT;
    localparam int X_W      = Q_W + 1;
    localparam int P_SHIFT  = 15;

    localparam int TEMP_BASE = 2000;
    localparam int LO_VLOW   = 3500;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    typedef enum logic [2:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMPERATURE  = 3'd4,
        REG_TEMPERATURE_COEFF      = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]          raw_pressure;
        logic signed [TEMP1_W-1:0] temp1;
        logic signed [LO_W-1:0]    lo;
        logic signed [VL_W-1:0]    vl;
        logic signed [OFF1_W-1:0]  off1;
        logic signed [SENS1_W-1:0] sens1;
        logic [T2_W-1:0]           t2;
        logic                      low;
        logic                      vlow;
    } fo_t;

    typedef struct packed {
        logic [RAW_W-1:0]         raw_pressure;
        logic signed [TOUT_W-1:0] temperature;
        logic                     temp_clip;
        logic signed [OS_W-1:0]   off;
        logic signed [OS_W-1:0]   sens;
    } so_t;

endpackage

>>> rtl/ptc_apb_regs.sv
// calibration register file behind the apb-style configuration port
module ptc_apb_regs import ptc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cal_t              cal
);

    cal_t     cal_reg;
    cal_t     cal_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cal    = cal_reg;

    always_comb begin
        cal_next = cal_reg;
        if (wr_en) begin
            case (idx)
                REG_PRESSURE_SENSITIVITY:   cal_next.pressure_sensitivity   = pwdata[CAL_W-1:0];
                REG_PRESSURE_OFFSET:        cal_next.pressure_offset        = pwdata[CAL_W-1:0];
                REG_SENSITIVITY_TEMP_COEFF: cal_next.sensitivity_temp_coeff = pwdata[CAL_W-1:0];
                REG_OFFSET_TEMP_COEFF:      cal_next.offset_temp_coeff      = pwdata[CAL_W-1:0];
                REG_REFERENCE_TEMPERATURE:  cal_next.reference_temperature  = pwdata[CAL_W-1:0];
                REG_TEMPERATURE_COEFF:      cal_next.temperature_coeff      = pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PRESSURE_SENSITIVITY:   prdata = APB_DW'(cal_reg.pressure_sensitivity);
            REG_PRESSURE_OFFSET:        prdata = APB_DW'(cal_reg.pressure_offset);
            REG_SENSITIVITY_TEMP_COEFF: prdata = APB_DW'(cal_reg.sensitivity_temp_coeff);
            REG_OFFSET_TEMP_COEFF:      prdata = APB_DW'(cal_reg.offset_temp_coeff);
            REG_REFERENCE_TEMPERATURE:  prdata = APB_DW'(cal_reg.reference_temperature);
            REG_TEMPERATURE_COEFF:      prdata = APB_DW'(cal_reg.temperature_coeff);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

endmodule

>>> rtl/ptc_first_order.sv
// first-order stages: temperature difference, products, temperature, offset and sensitivity
module ptc_first_order import ptc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cal_t             cal,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RAW_W-1:0] raw_pressure,
    input  logic [RAW_W-1:0] raw_temperature,
    output logic             out_valid,
    input  logic             out_ready,
    output fo_t              out_data
);

    logic                     a_valid_reg;
    logic [RAW_W-1:0]         a_p_reg;
    logic signed [DT_W-1:0]   a_dt_reg;
    logic signed [DT_W-1:0]   a_dt_next;

    logic                     b_valid_reg;
    logic [RAW_W-1:0]         b_p_reg;
    logic signed [PROD_W-1:0] b_pt_reg;
    logic signed [PROD_W-1:0] b_po_reg;
    logic signed [PROD_W-1:0] b_ps_reg;
    logic signed [DD_W-1:0]   b_pdd_reg;
    logic signed [PROD_W-1:0] b_pt_next;
    logic signed [PROD_W-1:0] b_po_next;
    logic signed [PROD_W-1:0] b_ps_next;
    logic signed [DD_W-1:0]   b_pdd_next;

    logic                     c_valid_reg;
    fo_t                      c_data_reg;
    fo_t                      c_data_next;

    logic                     en_a;
    logic                     en_b;
    logic                     en_c;
    logic signed [LO_W-1:0]   lo;

    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    assign a_dt_next = $signed({1'b0, raw_temperature})
                     - $signed({1'b0, cal.reference_temperature, 8'b0});

    assign b_pt_next  = a_dt_reg * $signed({1'b0, cal.temperature_coeff});
    assign b_po_next  = a_dt_reg * $signed({1'b0, cal.offset_temp_coeff});
    assign b_ps_next  = a_dt_reg * $signed({1'b0, cal.sensitivity_temp_coeff});
    assign b_pdd_next = a_dt_reg * a_dt_reg;

    assign lo = $signed(b_pt_reg[PROD_W-1:TC_SHIFT]);

    always_comb begin
        c_data_next.raw_pressure = b_p_reg;
        c_data_next.lo           = lo;
        c_data_next.temp1        = TEMP1_W'(lo) + TEMP1_W'(TEMP_BASE);
        c_data_next.vl           = VL_W'(lo) + VL_W'(LO_VLOW);
        c_data_next.off1         = OFF1_W'($signed(b_po_reg[PROD_W-1:OC_SHIFT]))
                                 + $signed({4'b0, cal.pressure_offset, 17'b0});
        c_data_next.sens1        = SENS1_W'($signed(b_ps_reg[PROD_W-1:SC_SHIFT]))
                                 + $signed({4'b0, cal.pressure_sensitivity, 16'b0});
        c_data_next.t2           = b_pdd_reg[T2_SHIFT+T2_W-1:T2_SHIFT];
        c_data_next.low          = lo[LO_W-1];
        c_data_next.vlow         = int'(lo) < -LO_VLOW;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= in_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
            if (en_c) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_p_reg  <= raw_pressure;
            a_dt_reg <= a_dt_next;
        end
        if (en_b) begin
            b_p_reg   <= a_p_reg;
            b_pt_reg  <= b_pt_next;
            b_po_reg  <= b_po_next;
            b_ps_reg  <= b_ps_next;
            b_pdd_reg <= b_pdd_next;
        end
        if (en_c) begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

>>> rtl/ptc_second_order.sv
// second-order stages: low and very-low temperature corrections, temperature clamp
module ptc_second_order import ptc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  fo_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output so_t  out_data
);

    logic                       d_valid_reg;
    logic [RAW_W-1:0]           d_p_reg;
    logic [SQ_W-1:0]            d_lo2_reg;
    logic [SQ_W-1:0]            d_vl2_reg;
    logic signed [TEMP_W-1:0]   d_temp_reg;
    logic signed [OFF1_W-1:0]   d_off1_reg;
    logic signed [SENS1_W-1:0]  d_sens1_reg;
    logic                       d_low_reg;
    logic                       d_vlow_reg;
    logic signed [2*LO_W-1:0]   lo_sq;
    logic signed [2*VL_W-1:0]   vl_sq;
    logic signed [TEMP_W-1:0]   d_temp_next;

    logic                       e_valid_reg;
    logic [RAW_W-1:0]           e_p_reg;
    logic [OS_W-1:0]            e_off2_reg;
    logic [OS_W-1:0]            e_sens2_reg;
    logic signed [OFF1_W-1:0]   e_off1_reg;
    logic signed [SENS1_W-1:0]  e_sens1_reg;
    logic signed [TOUT_W-1:0]   e_temp_reg;
    logic                       e_clip_reg;
    logic [OS_W-1:0]            e_off2_next;
    logic [OS_W-1:0]            e_sens2_next;
    logic signed [TOUT_W-1:0]   e_temp_next;
    logic                       e_clip_next;
    logic [OS_W-1:0]            lo2e;
    logic [OS_W-1:0]            vl2e;
    logic [OS_W-1:0]            lo2x5;

    logic                       f_valid_reg;
    so_t                        f_data_reg;
    so_t                        f_data_next;

    logic                       en_d;
    logic                       en_e;
    logic                       en_f;

    assign en_f     = !f_valid_reg || out_ready;
    assign en_e     = !e_valid_reg || en_f;
    assign en_d     = !d_valid_reg || en_e;
    assign in_ready = en_d;

    assign lo_sq       = in_data.lo * in_data.lo;
    assign vl_sq       = in_data.vl * in_data.vl;
    assign d_temp_next = TEMP_W'(in_data.temp1)
                       - (in_data.low ? $signed({4'b0, in_data.t2}) : TEMP_W'(0));

    assign lo2e  = OS_W'(d_lo2_reg);
    assign vl2e  = OS_W'(d_vl2_reg);
    assign lo2x5 = (lo2e << 2) + lo2e;

    always_comb begin
        e_off2_next  = '0;
        e_sens2_next = '0;
        if (d_low_reg) begin
            e_off2_next  = lo2x5 >> 1;
            e_sens2_next = lo2x5 >> 2;
            if (d_vlow_reg) begin
                e_off2_next  = e_off2_next + ((vl2e << 3) - vl2e);
                e_sens2_next = e_sens2_next + (((vl2e << 3) + (vl2e << 1) + vl2e) >> 1);
            end
        end
    end

    always_comb begin
        e_clip_next = 1'b0;
        e_temp_next = TOUT_W'(d_temp_reg);
        if (int'(d_temp_reg) < TEMP_MIN) begin
            e_temp_next = TOUT_W'(TEMP_MIN);
            e_clip_next = 1'b1;
        end else if (int'(d_temp_reg) > TEMP_MAX) begin
            e_temp_next = TOUT_W'(TEMP_MAX);
            e_clip_next = 1'b1;
        end
    end

    always_comb begin
        f_data_next.raw_pressure = e_p_reg;
        f_data_next.temperature  = e_temp_reg;
        f_data_next.temp_clip    = e_clip_reg;
        f_data_next.off          = OS_W'(e_off1_reg) - $signed(e_off2_reg);
        f_data_next.sens         = OS_W'(e_sens1_reg) - $signed(e_sens2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (en_d) d_valid_reg <= in_valid;
            if (en_e) e_valid_reg <= d_valid_reg;
            if (en_f) f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            d_p_reg     <= in_data.raw_pressure;
            d_lo2_reg   <= lo_sq[SQ_W-1:0];
            d_vl2_reg   <= vl_sq[SQ_W-1:0];
            d_temp_reg  <= d_temp_next;
            d_off1_reg  <= in_data.off1;
            d_sens1_reg <= in_data.sens1;
            d_low_reg   <= in_data.low;
            d_vlow_reg  <= in_data.vlow;
        end
        if (en_e) begin
            e_p_reg     <= d_p_reg;
            e_off2_reg  <= e_off2_next;
            e_sens2_reg <= e_sens2_next;
            e_off1_reg  <= d_off1_reg;
            e_sens1_reg <= d_sens1_reg;
            e_temp_reg  <= e_temp_next;
            e_clip_reg  <= e_clip_next;
        end
        if (en_f) begin
            f_data_reg <= f_data_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = f_data_reg;

endmodule

>>> rtl/ptc_pressure.sv
// pressure stages: split sensitivity product, offset subtract, clamp and output register
module ptc_pressure import ptc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  so_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TOUT_W-1:0] temperature,
    output logic [POUT_W-1:0] pressure,
    output logic              out_of_range
);

    logic                       f_valid_reg;
    logic [PL_W-1:0]            f_pl_reg;
    logic signed [PH_W-1:0]     f_ph_reg;
    logic signed [OS_W-1:0]     f_off_reg;
    logic signed [TOUT_W-1:0]   f_temp_reg;
    logic                       f_clip_reg;
    logic [PL_W-1:0]            f_pl_next;
    logic signed [PH_W-1:0]     f_ph_next;

    logic                       g_valid_reg;
    logic signed [Q_W-1:0]      g_q_reg;
    logic signed [OS_W-1:0]     g_off_reg;
    logic signed [TOUT_W-1:0]   g_temp_reg;
    logic                       g_clip_reg;
    logic signed [PSUM_W-1:0]   psum;

    logic                       o_valid_reg;
    logic [TOUT_W-1:0]          o_temp_reg;
    logic [POUT_W-1:0]          o_pres_reg;
    logic                       o_flag_reg;
    logic [POUT_W-1:0]          o_pres_next;
    logic                       o_flag_next;
    logic signed [X_W-1:0]      x;
    logic signed [X_W-P_SHIFT-1:0] pres;

    logic                       en_f;
    logic                       en_g;
    logic                       en_o;

    assign en_o     = !o_valid_reg || out_ready;
    assign en_g     = !g_valid_reg || en_o;
    assign en_f     = !f_valid_reg || en_g;
    assign in_ready = en_f;

    assign f_pl_next = in_data.raw_pressure * in_data.sens[SPLIT-1:0];
    assign f_ph_next = $signed({1'b0, in_data.raw_pressure})
                     * $signed(in_data.sens[OS_W-1:SPLIT]);

    assign psum = $signed({f_ph_reg, {SPLIT{1'b0}}})
                + $signed({{(PSUM_W-PL_W){1'b0}}, f_pl_reg});

    assign x    = X_W'(g_q_reg) - X_W'(g_off_reg);
    assign pres = x[X_W-1:P_SHIFT];

    always_comb begin
        o_flag_next = g_clip_reg;
        o_pres_next = POUT_W'(pres);
        if (int'(pres) < PRES_MIN) begin
            o_pres_next = POUT_W'(PRES_MIN);
            o_flag_next = 1'b1;
        end else if (int'(pres) > PRES_MAX) begin
            o_pres_next = POUT_W'(PRES_MAX);
            o_flag_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (en_f) f_valid_reg <= in_valid;
            if (en_g) g_valid_reg <= f_valid_reg;
            if (en_o) o_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f) begin
            f_pl_reg   <= f_pl_next;
            f_ph_reg   <= f_ph_next;
            f_off_reg  <= in_data.off;
            f_temp_reg <= in_data.temperature;
            f_clip_reg <= in_data.temp_clip;
        end
        if (en_g) begin
            g_q_reg    <= psum[PSUM_W-1:PSENS_SHIFT];
            g_off_reg  <= f_off_reg;
            g_temp_reg <= f_temp_reg;
            g_clip_reg <= f_clip_reg;
        end
        if (en_o) begin
            o_temp_reg <= g_temp_reg;
            o_pres_reg <= o_pres_next;
            o_flag_reg <= o_flag_next;
        end
    end

    assign out_valid    = o_valid_reg;
    assign temperature  = o_temp_reg;
    assign pressure     = o_pres_reg;
    assign out_of_range = o_flag_reg;

endmodule

>>> rtl/pressure_temperature_compensation.sv
// top level of the barometer pressure and temperature compensation pipeline
// Takes one raw pressure/temperature pair per cycle when not stalled and returns
// temperature in 0.01 degC and pressure in Pa after first- and second-order
// compensation with the six calibration words, both clamped to the rated range with
// a flag in m_tuser. The datapath is a nine-stage register pipeline (first order,
// second order, pressure), and one request can enter every cycle unless the output
// stalls; each stage holds its item while the stage after it is full and cannot
// advance, so a stalled output stops only as far back as the pipeline is occupied.
// Calibration registers sit at byte addresses 0x00 through 0x14; the user must write
// them only while the pipeline is empty, as the block itself does not enforce it.
module pressure_temperature_compensation import ptc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,  // temperature[14:0], pressure[31:15]
    output logic              m_tuser   // out_of_range
);

    cal_t              cal;
    logic              fo_valid;
    logic              fo_ready;
    fo_t               fo_data;
    logic              so_valid;
    logic              so_ready;
    so_t               so_data;
    logic [TOUT_W-1:0] temperature;
    logic [POUT_W-1:0] pressure;

    ptc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    ptc_first_order u_first (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cal             (cal),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .raw_pressure    (s_tdata[23:0]),
        .raw_temperature (s_tdata[47:24]),
        .out_valid       (fo_valid),
        .out_ready       (fo_ready),
        .out_data        (fo_data)
    );

    ptc_second_order u_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_data   (fo_data),
        .out_valid (so_valid),
        .out_ready (so_ready),
        .out_data  (so_data)
    );

    ptc_pressure u_pressure (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (so_valid),
        .in_ready     (so_ready),
        .in_data      (so_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .temperature  (temperature),
        .pressure     (pressure),
        .out_of_range (m_tuser)
    );

    assign m_tdata = {pressure, temperature};

endmodule

>>> rtl/ptc_checker.sv
// port-level checks on the result stream, bound to the top level
module ptc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    logic signed [14:0] temp_s;
    logic [16:0]        pres_u;
    logic               at_bound;

    assign temp_s   = $signed(m_tdata[14:0]);
    assign pres_u   = m_tdata[31:15];
    assign at_bound = (temp_s == -15'sd4000) || (temp_s == 15'sd8500)
                   || (pres_u == 17'd1000) || (pres_u == 17'd120000);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> temp_s >= -15'sd4000 && temp_s <= 15'sd8500
                  && pres_u >= 17'd1000 && pres_u <= 17'd120000)
        else $error("result outside rated range");

    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !at_bound |-> !m_tuser)
        else $error("range flag set on unclamped result");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_pressure_temperature_compensation.sv
// testbench for the pressure and temperature compensation pipeline with a scoreboard class
`timescale 1ns / 100ps

module tb_pressure_temperature_compensation import ptc_pkg::*; ;

    localparam int NUM_CAL      = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int VLOW_TEMP    = TEMP_BASE - LO_VLOW;
    localparam logic [APB_AW-1:0] ADDR_SPARE_LO = 5'h18;
    localparam logic [APB_AW-1:0] ADDR_SPARE_HI = 5'h1c;

    typedef struct {
        logic signed [TOUT_W-1:0] temperature;
        logic [POUT_W-1:0]        pressure;
        logic                     out_of_range;
    } reading_t;

    class compensation_scoreboard;
        logic [CAL_W-1:0] cal [NUM_CAL];
        reading_t         pending [$];
        int               errors;

        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
        endfunction

        function void set_cal(int idx, logic [APB_DW-1:0] value);
            if (idx < NUM_CAL) cal[idx] = value[CAL_W-1:0];
        endfunction

        function reading_t compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
            longint d1, d2, c1, c2, c3, c4, c5, c6;
            longint dt, temp, off, sens, t2, off2, sens2, lo, vl, pres;
            reading_t r;
            d1 = raw_p;
            d2 = raw_t;
            c1 = cal[REG_PRESSURE_SENSITIVITY];
            c2 = cal[REG_PRESSURE_OFFSET];
            c3 = cal[REG_SENSITIVITY_TEMP_COEFF];
            c4 = cal[REG_OFFSET_TEMP_COEFF];
            c5 = cal[REG_REFERENCE_TEMPERATURE];
            c6 = cal[REG_TEMPERATURE_COEFF];
            t2 = 0;
            off2 = 0;
            sens2 = 0;
            r.out_of_range = 1'b0;
            dt   = d2 - (c5 <<< 8);
            temp = TEMP_BASE + ((dt * c6) >>> TC_SHIFT);
            off  = (c2 <<< OFF_BASE_SHIFT) + ((c4 * dt) >>> OC_SHIFT);
            sens = (c1 <<< SENS_BASE_SHIFT) + ((c3 * dt) >>> SC_SHIFT);
            // second-order correction below 20 degC, extra term below -15 degC
            if (temp < TEMP_BASE) begin
                lo    = temp - TEMP_BASE;
                t2    = (dt * dt) >>> T2_SHIFT;
                off2  = (5 * lo * lo) >>> 1;
                sens2 = (5 * lo * lo) >>> 2;
                if (temp < VLOW_TEMP) begin
                    vl    = temp - VLOW_TEMP;
                    off2  = off2 + 7 * vl * vl;
                    sens2 = sens2 + ((11 * vl * vl) >>> 1);
                end
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
            pres = (((d1 * sens) >>> PSENS_SHIFT) - off) >>> P_SHIFT;
            if (temp < TEMP_MIN) begin
                temp = TEMP_MIN;
                r.out_of_range = 1'b1;
            end
            if (temp > TEMP_MAX) begin
                temp = TEMP_MAX;
                r.out_of_range = 1'b1;
            end
            if (pres < PRES_MIN) begin
                pres = PRES_MIN;
                r.out_of_range = 1'b1;
            end
            if (pres > PRES_MAX) begin
                pres = PRES_MAX;
                r.out_of_range = 1'b1;
            end
            r.temperature = TOUT_W'(temp);
            r.pressure    = POUT_W'(pres);
            return r;
        endfunction

        function void note_request(logic [47:0] data);
            pending.push_back(compensate(data[23:0], data[47:24]));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [31:0] data, logic flag);
            reading_t want;
            if (pending.size() == 0) begin
                report($sformatf("result %h/%b with no request waiting", data, flag));
            end else begin
                want = pending.pop_front();
                if (data[14:0] !== want.temperature)
                    report($sformatf("temperature want %0d got %0d",
                                     want.temperature, $signed(data[14:0])));
                if (data[31:15] !== want.pressure)
                    report($sformatf("pressure want %0d got %0d",
                                     want.pressure, data[31:15]));
                if (flag !== want.out_of_range)
                    report($sformatf("out_of_range want %b got %b",
                                     want.out_of_range, flag));
            end
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;  // raw_pressure[23:0], raw_temperature[47:24]
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;  // temperature[14:0], pressure[31:15]
    logic              m_tuser;  // out_of_range

    compensation_scoreboard sb = new();
    cal_t active_cal;
    int   cycle_count;
    bit   tx_quiet;
    bit   rx_quiet;

    pressure_temperature_compensation DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // result side: random stall before each result, with quiet stretches
    initial begin
        int n;
        m_tready = 1'b0;
        rx_quiet = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
            n = rx_quiet ? 0 : $urandom_range(0, 12);
            repeat (n) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic write_cal(logic [APB_AW-1:0] addr, logic [CAL_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = {16'($urandom), value};
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_cal(addr[APB_AW-1:2], word);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_cal(cal_t c);
        write_cal({REG_PRESSURE_SENSITIVITY, 2'b00}, c.pressure_sensitivity);
        write_cal({REG_PRESSURE_OFFSET, 2'b00}, c.pressure_offset);
        write_cal({REG_SENSITIVITY_TEMP_COEFF, 2'b00}, c.sensitivity_temp_coeff);
        write_cal({REG_OFFSET_TEMP_COEFF, 2'b00}, c.offset_temp_coeff);
        write_cal({REG_REFERENCE_TEMPERATURE, 2'b00}, c.reference_temperature);
        write_cal({REG_TEMPERATURE_COEFF, 2'b00}, c.temperature_coeff);
        active_cal = c;
    endtask

    task automatic send_pair(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
        int n;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        n = tx_quiet ? 0 : $urandom_range(0, 12);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_t, raw_p};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // raw temperature spread around the reference point so every correction branch is hit
    function automatic logic [RAW_W-1:0] near_reference();
        longint base, span, v;
        base = longint'(active_cal.reference_temperature) <<< 8;
        case ($urandom_range(0, 3))
            0:       span = 64'd4096;
            1:       span = 64'd1 << 20;
            2:       span = 64'd1 << 22;
            default: span = 64'd1 << 23;
        endcase
        v = base + longint'($urandom_range(0, 32'(2 * span))) - span;
        if (v < 0) v = 0;
        if (v > 64'hff_ffff) v = 64'hff_ffff;
        return RAW_W'(v);
    endfunction

    function automatic cal_t random_cal();
        cal_t c;
        c.pressure_sensitivity   = 16'($urandom);
        c.pressure_offset        = 16'($urandom);
        c.sensitivity_temp_coeff = 16'($urandom);
        c.offset_temp_coeff      = 16'($urandom);
        c.reference_temperature  = 16'($urandom);
        c.temperature_coeff      = 16'($urandom);
        return c;
    endfunction

    initial begin
        cal_t typical;
        cal_t c;
        logic [RAW_W-1:0] base;
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        tx_quiet = 1'b0;
        active_cal = '0;
        typical = {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // calibration still at reset values
        send_pair(24'd9085466, 24'd8569150);
        send_pair('1, '1);
        settle();

        load_cal(typical);
        write_cal(ADDR_SPARE_LO, 16'hffff);
        write_cal(ADDR_SPARE_HI, 16'h0000);
        base = RAW_W'(longint'(typical.reference_temperature) <<< 8);
        send_pair(24'd9085466, base);
        send_pair(24'd9085466, base - 24'd1);
        send_pair(24'd9085466, base - 24'd200000);
        send_pair(24'd9085466, base - 24'd1037000);
        send_pair(24'd9085466, base - 24'd1037100);
        send_pair('1, base + 24'd4000000);
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair('0, base);
        send_pair('1, base);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       c = typical;
                1:       c = '1;
                2:       c = '0;
                3:       c = {16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff};
                4:       c = {16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000};
                default: c = random_cal();
            endcase
            load_cal(c);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) < 7)
                    send_pair(RAW_W'($urandom), near_reference());
                else
                    send_pair(RAW_W'($urandom), RAW_W'($urandom));
            end
            settle();
        end

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
